>>> hw/rtl/compacting_value_list_store_macros.svh
// Assertion helpers used by the list store datapath.
// Every check samples on the rising edge of clk and is off while rst is high.
`ifndef COMPACTING_VALUE_LIST_STORE_MACROS_SVH
`define COMPACTING_VALUE_LIST_STORE_MACROS_SVH

// Implication in the same cycle.
`define CVLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define CVLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cvls_pkg.sv
package cvls_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int POS_W   = 7;
  localparam int COUNT_W = 7;
  localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [CMP_W-1:0]   cmp_t;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_MEMBER = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // capture the incoming transaction
    logic exec;   // run the captured command against the cell row
  } ctl_cmd_t;

endpackage

>>> hw/rtl/cvls_ctrl.sv
module cvls_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output cvls_pkg::ctl_cmd_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Take a new transaction when idle, or when the pending response leaves.
  assign cmd_stall = !((state == S_IDLE) || ((state == S_DONE) && !rsp_stall));
  assign accept    = cmd_valid && !cmd_stall;
  assign rsp_valid = (state == S_DONE);

  assign ctl.load = accept;
  assign ctl.exec = (state == S_EXEC);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_stall) state_next = accept ? S_EXEC : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/cvls_datapath.sv
`include "compacting_value_list_store_macros.svh"

module cvls_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  cvls_pkg::ctl_cmd_t          ctl,
  input  logic [2:0]                  cmd,
  input  logic signed [31:0]          value,
  input  logic [cvls_pkg::POS_W-1:0]  position,
  output logic [1:0]                  status,
  output logic signed [31:0]          read_value,
  output logic [cvls_pkg::COUNT_W-1:0] count
);

  localparam int DEPTH = cvls_pkg::DEPTH;
  localparam int IDX_W = cvls_pkg::IDX_W;

  // Captured transaction
  logic [2:0]      cmd_q;
  cvls_pkg::word_t value_q;
  cvls_pkg::pos_t  position_q;

  // Slot row and fill level
  cvls_pkg::word_t slot [DEPTH];
  cvls_pkg::cnt_t  entry_count;
  cvls_pkg::cnt_t  entry_count_next;
  cvls_pkg::cnt_t  count_inc;
  cvls_pkg::cnt_t  count_dec;

  // Response registers
  cvls_pkg::status_e status_q;
  cvls_pkg::status_e status_d;
  cvls_pkg::word_t   read_value_q;
  cvls_pkg::word_t   rd_d;

  logic [DEPTH-1:0] live;
  logic [DEPTH-1:0] hit;
  logic [DEPTH-1:0] prefix [IDX_W+1];
  logic [DEPTH-1:0] after;
  logic [DEPTH-1:0] rd_sel;
  logic [DEPTH-1:0] app_we;
  logic [DEPTH-1:0] del_we;
  logic             found;
  logic             full;
  logic             rd_hit;
  logic             exec_append;
  logic             exec_delete;
  cvls_pkg::word_t  rd_word;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q      <= cmd;
      value_q    <= cvls_pkg::word_t'(value);
      position_q <= position;
    end
  end

  // Per-slot compare and position decode.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      live[i]   = cvls_pkg::cmp_t'(i) < cvls_pkg::cmp_t'(entry_count);
      hit[i]    = live[i] && (slot[i] == value_q);
      rd_sel[i] = live[i] && (cvls_pkg::cmp_t'(position_q) == cvls_pkg::cmp_t'(i + 1));
    end
  end

  // Parallel prefix OR: after[i] is set at and beyond the first hit.
  always_comb begin
    prefix[0] = hit;
    for (int k = 0; k < IDX_W; k++) begin
      prefix[k+1] = prefix[k] | (prefix[k] << (1 << k));
    end
  end

  assign after     = prefix[IDX_W];
  assign found     = |hit;
  assign rd_hit    = |rd_sel;
  assign full      = (entry_count == cvls_pkg::cnt_t'(DEPTH));
  assign count_inc = entry_count + 1'b1;
  assign count_dec = entry_count - 1'b1;

  assign exec_append = ctl.exec && (cmd_q == cvls_pkg::CMD_APPEND);
  assign exec_delete = ctl.exec && (cmd_q == cvls_pkg::CMD_DELETE);

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | ({cvls_pkg::WORD_W{rd_sel[i]}} & slot[i]);
    end
  end

  always_comb begin
    entry_count_next = entry_count;
    status_d         = cvls_pkg::ST_OK;
    rd_d             = '0;
    app_we           = '0;
    del_we           = '0;
    if (ctl.exec) begin
      unique case (cmd_q)
        cvls_pkg::CMD_APPEND: begin
          if (full) begin
            status_d = cvls_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              app_we[i] = (cvls_pkg::cnt_t'(i) == entry_count);
            end
            entry_count_next = count_inc;
          end
        end
        cvls_pkg::CMD_DELETE: begin
          if (!found) begin
            status_d = cvls_pkg::ST_NOT_FOUND;
          end else begin
            // Close the gap: every slot from the first hit on, but the top one, takes its upper neighbor.
            del_we           = after;
            entry_count_next = count_dec;
          end
        end
        cvls_pkg::CMD_MEMBER: begin
          if (!found) status_d = cvls_pkg::ST_NOT_FOUND;
        end
        cvls_pkg::CMD_READ: begin
          if (!rd_hit) begin
            status_d = cvls_pkg::ST_RANGE;
          end else begin
            rd_d = rd_word;
          end
        end
        cvls_pkg::CMD_CLEAR: begin
          entry_count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_slot
    if (g < DEPTH - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (del_we[g]) begin
          slot[g] <= slot[g+1];
        end else if (app_we[g]) begin
          slot[g] <= value_q;
        end
      end
    end else begin : g_top
      // Top slot never shifts; it is beyond the count after a delete.
      always_ff @(posedge clk) begin
        if (app_we[g]) begin
          slot[g] <= value_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else begin
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      status_q     <= status_d;
      read_value_q <= rd_d;
    end
  end

  assign status     = status_q;
  assign read_value = read_value_q;
  assign count      = cvls_pkg::count_t'(entry_count);

  `CVLS_ASSERT_NEXT(a_count_hold, !ctl.exec, $stable(entry_count), "count moved while idle")
  `CVLS_ASSERT_NEXT(a_append_grow, exec_append && !full, entry_count == $past(count_inc), "no grow")
  `CVLS_ASSERT_NEXT(a_append_full, exec_append && full, status_q == cvls_pkg::ST_FULL, "no full")
  `CVLS_ASSERT_NEXT(a_delete_shrink, exec_delete && found, entry_count == $past(count_dec), "no shrink")
  `CVLS_ASSERT_NOW(a_hit_live, found, entry_count != '0, "match reported on an empty list")

endmodule

>>> hw/rtl/compacting_value_list_store.sv
// Response: an accepted command transaction passes through state S_EXEC to S_DONE, where
// the registered response is presented and held until it is taken.
// Flow: each command runs in S_EXEC through the compare and shift row of 64 slots, whose
// result is registered; the next command is taken in the cycle its predecessor's response
// is taken, and not before.
// Reset: synchronous; the entry count and controller clear, stored words are left as they
// are and need no clearing pass.
module compacting_value_list_store (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [2:0]                   cmd,
  input  logic signed [31:0]           value,
  input  logic [cvls_pkg::POS_W-1:0]   position,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [1:0]                   status,
  output logic signed [31:0]           read_value,
  output logic [cvls_pkg::COUNT_W-1:0] count
);

  cvls_pkg::ctl_cmd_t ctl;

  cvls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ctl       (ctl)
  );

  cvls_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cmd        (cmd),
    .value      (value),
    .position   (position),
    .status     (status),
    .read_value (read_value),
    .count      (count)
  );

endmodule
